// ===== rtl/sst_pkg.sv =====
package sst_pkg;

  localparam int SST_CAPACITY = 1024;
  localparam int KEY_W        = 16;
  localparam int COUNT_W      = 11;
  localparam int TREE_RADIX   = 16;

  localparam logic [1:0] KIND_MEMBER = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
  } sst_in_t;

  typedef struct packed {
    logic               success;
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;
  } sst_out_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             capture;
    logic             ins;
    logic             del;
    logic [KEY_W-1:0] key;
  } sst_cmd_t;

  // number of registered levels in the match reduction tree
  function automatic int tree_levels(input int n);
    int m;
    int lv;
    m  = n;
    lv = 0;
    do begin
      m  = (m + TREE_RADIX - 1) / TREE_RADIX;
      lv = lv + 1;
    end while (m > 1);
    return lv;
  endfunction

  // node count of level l (level 0 is the leaves)
  function automatic int level_nodes(input int n, input int l);
    int m;
    m = n;
    for (int i = 0; i < l; i++) begin
      m = (m + TREE_RADIX - 1) / TREE_RADIX;
    end
    return m;
  endfunction

  // offset of level l (l >= 1) within the packed register vector of the tree
  function automatic int level_base(input int n, input int l);
    int b;
    b = 0;
    for (int i = 1; i < l; i++) begin
      b = b + level_nodes(n, i);
    end
    return b;
  endfunction

endpackage

// ===== rtl/sst_cell.sv =====
module sst_cell
  import sst_pkg::*;
(
  input  logic             clk,
  input  sst_cmd_t         cmd,
  input  logic             occ,
  input  logic             lt_prev,
  input  logic [KEY_W-1:0] key_prev,
  input  logic [KEY_W-1:0] key_next,
  output logic [KEY_W-1:0] key_o,
  output logic             lt_o,
  output logic             eq_o
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic             lt_r, eq_r;

  always_comb begin
    key_nxt = key_r;
    // cells below the slot keep their key, the rest move one place
    if (cmd.ins && !lt_r) begin
      key_nxt = lt_prev ? cmd.key : key_prev;
    end else if (cmd.del && !lt_r) begin
      key_nxt = key_next;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (cmd.capture) begin
      lt_r <= occ && (key_r < cmd.key);
      eq_r <= occ && (key_r == cmd.key);
    end
  end

  assign key_o = key_r;
  assign lt_o  = lt_r;
  assign eq_o  = eq_r;

endmodule

// ===== rtl/sst_or_tree.sv =====
module sst_or_tree
  import sst_pkg::*;
#(
  parameter int N = SST_CAPACITY
) (
  input  logic         clk,
  input  logic [N-1:0] leaves,
  output logic         any_o
);

  localparam int LEVELS = tree_levels(N);
  localparam int NODES  = level_base(N, LEVELS + 1);

  logic [NODES-1:0] node_r;

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    localparam int NPREV = level_nodes(N, l - 1);
    localparam int NCUR  = level_nodes(N, l);
    localparam int BCUR  = level_base(N, l);
    localparam int BPREV = (l > 1) ? level_base(N, l - 1) : 0;
    for (genvar j = 0; j < NCUR; j++) begin : g_node
      localparam int LO  = j * TREE_RADIX;
      localparam int CNT = (NPREV - LO < TREE_RADIX) ? (NPREV - LO) : TREE_RADIX;
      logic or_r;
      if (l == 1) begin : g_leaf
        always_ff @(posedge clk) begin
          or_r <= |leaves[LO +: CNT];
        end
      end else begin : g_inner
        always_ff @(posedge clk) begin
          or_r <= |node_r[BPREV + LO +: CNT];
        end
      end
      assign node_r[BCUR + j] = or_r;
    end
  end

  assign any_o = node_r[NODES-1];

endmodule

// ===== rtl/sorted_set_table.sv =====
// channel  dir  signals                          beat
// in       in   in_valid, in_ready, in_data      one operation (kind, key)
// out      out  out_valid, out_ready, out_data   one result per operation
//
// each item goes through these steps in order: the item is latched, every cell compares
// its key, the per-cell match flags climb a registered or-tree of L levels, with
// L = ceil(log16(CAPACITY)) and at least 1, and then the row shifts.
// reset clears the entry count and control; the cell keys are never reset.
// a finished result waits in the output register while the next item is
// taken; that item then holds in its last cycle until the result is taken.
module sorted_set_table
  import sst_pkg::*;
#(
  parameter int CAPACITY = SST_CAPACITY
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sst_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sst_out_t out_data
);

  localparam int OCC_W  = $clog2(CAPACITY + 1);
  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int CNT_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_TREE = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  sst_in_t          item_r;
  logic             out_valid_r, out_valid_nxt;
  sst_out_t         out_data_r, out_data_nxt;

  sst_cmd_t         cmd;
  logic             held;
  logic             full;
  logic             slot_free;
  logic             finish;
  logic             do_ins, do_del;

  logic [CAPACITY-1:0] occ_w, lt_w, eq_w;
  logic [KEY_W-1:0]    key_w [CAPACITY];
  logic [COUNT_W+OCC_W-1:0] count_wide;

  assign full      = (occ_r == OCC_W'(CAPACITY));
  assign slot_free = !out_valid_r || out_ready;
  assign finish    = (state_r == S_DONE) && slot_free;
  assign do_ins    = finish && (item_r.kind == KIND_INSERT) && !held && !full;
  assign do_del    = finish && (item_r.kind == KIND_DELETE) && held;

  assign cmd.capture = (state_r == S_CMP);
  assign cmd.ins     = do_ins;
  assign cmd.del     = do_del;
  assign cmd.key     = item_r.key;

  // row of cells, each holding one key of the ordered set
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             lt_prev;
    logic [KEY_W-1:0] key_prev, key_next;
    assign occ_w[i] = (OCC_W'(i) < occ_r);
    if (i == 0) begin : g_first
      assign lt_prev  = 1'b1;
      assign key_prev = item_r.key;
    end else begin : g_mid
      assign lt_prev  = lt_w[i-1];
      assign key_prev = key_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign key_next = key_w[i];
    end else begin : g_body
      assign key_next = key_w[i+1];
    end
    sst_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .occ      (occ_w[i]),
      .lt_prev  (lt_prev),
      .key_prev (key_prev),
      .key_next (key_next),
      .key_o    (key_w[i]),
      .lt_o     (lt_w[i]),
      .eq_o     (eq_w[i])
    );
  end

  sst_or_tree #(.N(CAPACITY)) u_tree (
    .clk    (clk),
    .leaves (eq_w),
    .any_o  (held)
  );

  always_comb begin
    occ_nxt = occ_r;
    if (do_ins) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (do_del) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  assign count_wide = {COUNT_W'(0), occ_nxt};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_TREE;
        cnt_nxt   = '0;
      end
      S_TREE: begin
        // wait until the match has climbed the whole tree
        if (cnt_r == CNT_W'(LEVELS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt                = S_IDLE;
          out_valid_nxt            = 1'b1;
          out_data_nxt.entry_count = count_wide[COUNT_W-1:0];
          case (item_r.kind)
            KIND_INSERT: begin
              out_data_nxt.success = do_ins;
              out_data_nxt.status  = held ? ST_PRESENT : (full ? ST_FULL : ST_DONE);
            end
            KIND_DELETE: begin
              out_data_nxt.success = held;
              out_data_nxt.status  = held ? ST_DONE : ST_ABSENT;
            end
            default: begin
              out_data_nxt.success = held;
              out_data_nxt.status  = held ? ST_DONE : ST_ABSENT;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_occ_bound : assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_ins_count : assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> (occ_r == $past(occ_r) + OCC_W'(1)))
    else $error("insert did not grow the entry count");

  a_ok_status : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.success && (out_data_r.status != ST_DONE)))
    else $error("success beat with a failure status");

  a_full_refuse : assert property (@(posedge clk) disable iff (!rst_n)
    (finish && full) |-> !do_ins)
    else $error("insert taken into a full store");

endmodule
